[hdl/file_command_line_parser_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the command line parser
// Clocked, reset-qualified property forms shared by the checker.
// ---------------------------------------------------------------------------
`ifndef FILE_COMMAND_LINE_PARSER_ASSERT_SVH
`define FILE_COMMAND_LINE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FCLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fclp_pkg.sv]
// ---------------------------------------------------------------------------
// fclp_pkg
// Types, codes and helper functions of the command line parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fclp_pkg;

  localparam int MAX_LINE_DEF = 1024;

  localparam int NUM_W      = 31;
  localparam int TEXT_OFF_W = 10;
  localparam int TEXT_LEN_W = 11;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Bits of the field flag word.
  localparam int FLAG_FD   = 4;
  localparam int FLAG_SIZE = 5;
  localparam int FLAG_BAD2 = 6;
  localparam int FLAG_BAD4 = 7;

  typedef enum logic [3:0] {
    CMD_ERR = 4'd0,
    CMD_CON = 4'd1,
    CMD_LSD = 4'd2,
    CMD_DEL = 4'd3,
    CMD_CRE = 4'd4,
    CMD_OPN = 4'd5,
    CMD_WRT = 4'd6,
    CMD_REA = 4'd7,
    CMD_CLO = 4'd8,
    CMD_BYE = 4'd9
  } cmd_t;

  localparam int NUM_KEYS = 9;

  // Keywords in command code order, code = index + 1.
  localparam logic [23:0] KEYWORDS [NUM_KEYS] = '{
    24'h434F4E, 24'h4C5344, 24'h44454C, 24'h435245, 24'h4F504E,
    24'h575254, 24'h524541, 24'h434C4F, 24'h425945
  };

  localparam logic [31:0] KEY_FD   = 32'h0000_4644;
  localparam logic [31:0] KEY_SIZE = 32'h5349_5A45;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } line_word_t;

  typedef struct packed {
    logic [3:0]            command;
    logic [NUM_W-1:0]      descriptor;
    logic [NUM_W-1:0]      byte_count;
    logic [TEXT_OFF_W-1:0] text_offset;
    logic [TEXT_LEN_W-1:0] text_length;
  } result_word_t;

  // Parser status handed from the scanner to the result logic.
  typedef struct packed {
    logic [3:0] cmd;
    logic [2:0] sep;
    logic [7:0] flags;
  } scan_info_t;

  function automatic logic [3:0] key_code(input logic [31:0] chars,
                                          input logic [2:0]  len);
    logic [3:0] code;
    code = CMD_ERR;
    if (len == 3'd3) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (chars == {8'h00, KEYWORDS[k]}) code = 4'(k + 1);
      end
    end
    return code;
  endfunction

  function automatic logic is_fd(input logic [31:0] chars, input logic [2:0] len);
    return (len == 3'd2) && (chars == KEY_FD);
  endfunction

  function automatic logic is_size(input logic [31:0] chars, input logic [2:0] len);
    return (len == 3'd4) && (chars == KEY_SIZE);
  endfunction

  // Times ten plus digit, saturating.
  function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] v,
                                                  input logic [3:0]       d);
    logic [NUM_W+3:0] n;
    n = (NUM_W+4)'({v, 3'b000}) + (NUM_W+4)'({v, 1'b0}) + (NUM_W+4)'(d);
    return (n > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : n[NUM_W-1:0];
  endfunction

endpackage

[hdl/fclp_scan.sv]
// ---------------------------------------------------------------------------
// fclp_scan
// Parser state and per-byte update; also closes the open field on the end word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fclp_scan import fclp_pkg::*; #(
  parameter  int MAX_LINE = MAX_LINE_DEF,
  localparam int PosW     = $clog2(MAX_LINE + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       line_byte,
  input  logic             line_end,
  output scan_info_t       info,
  output logic [NUM_W-1:0] first_num,
  output logic [NUM_W-1:0] second_num,
  output logic [PosW-1:0]  pos_fin,
  output logic [PosW-1:0]  name_start_fin,
  output logic [PosW-1:0]  name_len_fin,
  output logic [PosW-1:0]  rem_start_fin
);

  logic [PosW-1:0]  pos, pos_next;
  logic [2:0]       sep, sep_next;
  logic             stop, stop_next;
  logic [31:0]      tchars, tchars_next;
  logic [2:0]       tlen, tlen_next;
  logic [3:0]       cmd, cmd_next;
  logic [PosW-1:0]  name_start, name_start_next;
  logic [PosW-1:0]  name_len, name_len_next;
  logic [NUM_W-1:0] num1, num1_next;
  logic [NUM_W-1:0] num2, num2_next;
  logic [7:0]       flags, flags_next;
  logic [PosW-1:0]  rem_start, rem_start_next;

  logic take;
  logic digit;

  assign take  = !stop && (line_byte >= CHAR_SPACE) && (line_byte <= CHAR_TILDE) &&
                 (pos < PosW'(MAX_LINE));
  assign digit = (line_byte >= CHAR_ZERO) && (line_byte <= CHAR_NINE);

  always_comb begin
    pos_next        = pos;
    sep_next        = sep;
    stop_next       = stop | !take;
    tchars_next     = tchars;
    tlen_next       = tlen;
    cmd_next        = cmd;
    name_start_next = name_start;
    name_len_next   = name_len;
    num1_next       = num1;
    num2_next       = num2;
    flags_next      = flags;
    rem_start_next  = rem_start;
    if (take) begin
      if (sep < 3'd5 && line_byte == CHAR_SPACE) begin
        if (sep == 3'd0) begin
          cmd_next        = key_code(tchars, tlen);
          name_start_next = pos + PosW'(1);
        end
        if (sep == 3'd1) begin
          if (is_fd(tchars, tlen)) flags_next[FLAG_FD] = 1'b1;
          name_len_next = pos - name_start;
        end
        if (sep == 3'd3 && is_size(tchars, tlen)) flags_next[FLAG_SIZE] = 1'b1;
        if (sep == 3'd4) rem_start_next = pos + PosW'(1);
        tchars_next = '0;
        tlen_next   = '0;
        sep_next    = sep + 3'd1;
      end else if (sep < 3'd5) begin
        if (sep != 3'd0) flags_next[3'(sep - 3'd1)] = 1'b1;
        if (tlen < 3'd4) tchars_next = {tchars[23:0], line_byte};
        if (tlen < 3'd5) tlen_next = tlen + 3'd1;
        if (sep == 3'd2) begin
          if (digit) num1_next = accumulate(num1, line_byte[3:0]);
          else       flags_next[FLAG_BAD2] = 1'b1;
        end
        if (sep == 3'd4) begin
          if (digit) num2_next = accumulate(num2, line_byte[3:0]);
          else       flags_next[FLAG_BAD4] = 1'b1;
        end
      end
      pos_next = pos + PosW'(1);
    end
  end

  // Close whatever field is still open after this byte.
  always_comb begin
    info.cmd     = cmd_next;
    info.sep     = sep_next;
    info.flags   = flags_next;
    name_len_fin = name_len_next;
    if (sep_next == 3'd0) info.cmd = key_code(tchars_next, tlen_next);
    if (sep_next == 3'd1) begin
      if (is_fd(tchars_next, tlen_next)) info.flags[FLAG_FD] = 1'b1;
      name_len_fin = pos_next - name_start_next;
    end
    if (sep_next == 3'd3 && is_size(tchars_next, tlen_next)) info.flags[FLAG_SIZE] = 1'b1;
  end

  assign first_num      = num1_next;
  assign second_num     = num2_next;
  assign pos_fin        = pos_next;
  assign name_start_fin = name_start_next;
  assign rem_start_fin  = rem_start_next;

  always_ff @(posedge clk) begin
    if (rst || (step && line_end)) begin
      pos        <= '0;
      sep        <= '0;
      stop       <= 1'b0;
      tchars     <= '0;
      tlen       <= '0;
      cmd        <= '0;
      name_start <= '0;
      name_len   <= '0;
      num1       <= '0;
      num2       <= '0;
      flags      <= '0;
      rem_start  <= '0;
    end else if (step) begin
      pos        <= pos_next;
      sep        <= sep_next;
      stop       <= stop_next;
      tchars     <= tchars_next;
      tlen       <= tlen_next;
      cmd        <= cmd_next;
      name_start <= name_start_next;
      name_len   <= name_len_next;
      num1       <= num1_next;
      num2       <= num2_next;
      flags      <= flags_next;
      rem_start  <= rem_start_next;
    end
  end

endmodule

[hdl/fclp_judge.sv]
// ---------------------------------------------------------------------------
// fclp_judge
// Argument checks per command and assembly of the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fclp_judge import fclp_pkg::*; #(
  parameter  int MAX_LINE = MAX_LINE_DEF,
  localparam int PosW     = $clog2(MAX_LINE + 1)
) (
  input  scan_info_t       info,
  input  logic [NUM_W-1:0] first_num,
  input  logic [NUM_W-1:0] second_num,
  input  logic [PosW-1:0]  pos_fin,
  input  logic [PosW-1:0]  name_start_fin,
  input  logic [PosW-1:0]  name_len_fin,
  input  logic [PosW-1:0]  rem_start_fin,
  output result_word_t     result
);

  logic [PosW-1:0]  rem_len;
  logic             e1, e2, e3, e4, e5, fd_ok, size_ok, n2, n4, ok;
  logic [NUM_W-1:0] fd, size;
  logic [PosW-1:0]  toff, tlen;
  cmd_t             cmd;

  assign cmd     = cmd_t'(info.cmd);
  assign rem_len = (info.sep == 3'd5 && pos_fin > rem_start_fin) ?
                   pos_fin - rem_start_fin : '0;
  assign e1      = info.flags[0];
  assign e2      = info.flags[1];
  assign e3      = info.flags[2];
  assign e4      = info.flags[3];
  assign e5      = (rem_len != '0);
  assign fd_ok   = info.flags[FLAG_FD];
  assign size_ok = info.flags[FLAG_SIZE];
  assign n2      = e2 && !info.flags[FLAG_BAD2];
  assign n4      = e4 && !info.flags[FLAG_BAD4];

  always_comb begin
    ok   = 1'b0;
    fd   = '0;
    size = '0;
    toff = '0;
    tlen = '0;
    unique case (cmd) inside
      CMD_CON, CMD_LSD, CMD_BYE: begin
        ok = !e1 && !e2 && !e3 && !e4 && !e5;
      end
      CMD_DEL, CMD_CRE, CMD_OPN: begin
        ok = !e2 && !e3 && !e4 && !e5;
        if (name_len_fin != '0) begin
          toff = name_start_fin;
          tlen = name_len_fin;
        end
      end
      CMD_WRT, CMD_REA: begin
        ok   = fd_ok && size_ok && n2 && n4 && (cmd == CMD_WRT || !e5);
        fd   = first_num;
        size = second_num;
        if (cmd == CMD_WRT && e5) begin
          toff = rem_start_fin;
          tlen = rem_len;
        end
      end
      CMD_CLO: begin
        ok = fd_ok && n2 && !e3 && !e4 && !e5;
        fd = first_num;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ok) begin
      result.command     = info.cmd;
      result.descriptor  = fd;
      result.byte_count  = size;
      result.text_offset = TEXT_OFF_W'(toff);
      result.text_length = TEXT_LEN_W'(tlen);
    end else begin
      result = '0;
    end
  end

endmodule

[hdl/file_command_line_parser.sv]
// ---------------------------------------------------------------------------
// file_command_line_parser
// Byte-serial parser for file service command lines.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// One command line enters as a run of words, one byte each, the last one
// flagged by line_end. The block takes one word every cycle with no gaps
// while line_stall is low: each byte passes through an input register, a
// single pass of compare and times-ten accumulate logic, and, for the end
// word only, into the result register, which loads when the end word
// advances. Exactly one result comes out per line. line_stall rises only
// while the result register holds an untaken result and an end word waits
// behind it; until then, ordinary bytes keep flowing while the result waits.
// After reset the block is ready at once: there is no memory and no clearing pass.
module file_command_line_parser import fclp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         line_valid,
  output logic         line_stall,
  input  line_word_t   line_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  localparam int PosW = $clog2(MAX_LINE + 1);

  // Input register.
  logic       in_valid;
  line_word_t in_word;

  logic out_free;
  logic step;

  scan_info_t       info;
  logic [NUM_W-1:0] first_num, second_num;
  logic [PosW-1:0]  pos_fin, name_start_fin, name_len_fin, rem_start_fin;
  result_word_t     result_next;

  // Result register is free when empty or being taken this cycle.
  assign out_free = !result_valid || !result_stall;

  // Advance the held byte unless it is an end word with nowhere to go.
  assign step = in_valid && (!in_word.line_end || out_free);

  // Hold the input side only while the held byte cannot advance.
  assign line_stall = in_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!line_stall) begin
      in_valid <= line_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!line_stall && line_valid) begin
      in_word <= line_word;
    end
  end

  fclp_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .line_byte     (in_word.line_byte),
    .line_end      (in_word.line_end),
    .info          (info),
    .first_num     (first_num),
    .second_num    (second_num),
    .pos_fin       (pos_fin),
    .name_start_fin(name_start_fin),
    .name_len_fin  (name_len_fin),
    .rem_start_fin (rem_start_fin)
  );

  fclp_judge #(
    .MAX_LINE(MAX_LINE)
  ) u_judge (
    .info          (info),
    .first_num     (first_num),
    .second_num    (second_num),
    .pos_fin       (pos_fin),
    .name_start_fin(name_start_fin),
    .name_len_fin  (name_len_fin),
    .rem_start_fin (rem_start_fin),
    .result        (result_next)
  );

  // Result register: load on the end word, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && in_word.line_end) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_word.line_end) begin
      result_word <= result_next;
    end
  end

endmodule

[hdl/fclp_checker.sv]
// ---------------------------------------------------------------------------
// fclp_checker
// Port-level checks of the command line parser, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "file_command_line_parser_assert.svh"

module fclp_checker import fclp_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         line_valid,
  input logic         line_stall,
  input line_word_t   line_word,
  input logic         result_valid,
  input logic         result_stall,
  input result_word_t result_word
);

  `FCLP_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_word), "stalled result changed")
  `FCLP_ASSERT_NOW(a_stall_cause, clk, rst, line_stall, result_valid && result_stall, "input stalled without a blocked result")
  `FCLP_ASSERT_NOW(a_error_clean, clk, rst, result_valid && result_word.command == CMD_ERR, result_word.descriptor == '0 && result_word.byte_count == '0 && result_word.text_offset == '0 && result_word.text_length == '0, "error result carries data")
  `FCLP_ASSERT_NOW(a_empty_text, clk, rst, result_valid && result_word.text_length == '0, result_word.text_offset == '0, "offset given for empty text")
  `FCLP_ASSERT_NOW(a_fd_cmd, clk, rst, result_valid && result_word.descriptor != '0, result_word.command == CMD_WRT || result_word.command == CMD_REA || result_word.command == CMD_CLO, "descriptor on a command without one")

endmodule

bind file_command_line_parser fclp_checker u_fclp_checker (.*);
